>>> rtl/dtic_pkg.sv
// Shared types and register map of the dual timer interrupt controller.
package dtic_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  localparam int AddrW  = 6;
  localparam int DataW  = 8;
  localparam int CountW = 16;
  localparam int NumTmr = 2;

  localparam logic [AddrW-1:0] ADDR_IRQ       = 6'd0;
  localparam logic [AddrW-1:0] ADDR_TMR_STAT  = 6'd1;
  localparam logic [AddrW-1:0] ADDR_CNT0_LO   = 6'd32;
  localparam logic [AddrW-1:0] ADDR_CNT0_HI   = 6'd33;
  localparam logic [AddrW-1:0] ADDR_CNT1_LO   = 6'd34;
  localparam logic [AddrW-1:0] ADDR_CNT1_HI   = 6'd35;
  localparam logic [AddrW-1:0] ADDR_CNT_RD_LO = 6'd36;
  localparam logic [AddrW-1:0] ADDR_CNT_RD_HI = 6'd37;

  typedef logic [CountW-1:0] count_t;

endpackage

>>> rtl/dual_timer_irq_controller.sv
// Dual 16-bit down-counting timers with a small interrupt controller.
// A transaction passes through the input register and then the result register to out_*.
// Throughput: one transaction per cycle while the result side is not stalled; each
//   tick, read or write is a compare and a 16-bit decrement per timer and a byte select
//   between the input and result registers.
// Reset (rst_n low, synchronous) clears both valids, enable mask, pending bits, counts.
module dual_timer_irq_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] address, [13:6] write_data, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_data, [8] irq_out, [15:9] zero
);
  import dtic_pkg::*;

  // input register
  logic             in_v_r;
  op_t              op_r;
  logic [AddrW-1:0] addr_r;
  logic [DataW-1:0] wdata_r;

  // result register
  logic             out_v_r;
  logic [DataW-1:0] rdata_r;
  logic             irq_r;

  // block state
  logic [DataW-1:0]  en_r,   en_nxt;
  logic [NumTmr-1:0] pend_r, pend_nxt;
  count_t            cnt_r   [NumTmr];
  count_t            cnt_nxt [NumTmr];
  logic [DataW-1:0]  rdata_nxt;
  logic              irq_nxt;

  logic advance;
  count_t cnt_sel;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  // shared count read follows timer 1 while it is pending
  assign cnt_sel = pend_r[1] ? cnt_r[1] : cnt_r[0];

  always_comb begin
    en_nxt     = en_r;
    pend_nxt   = pend_r;
    cnt_nxt[0] = cnt_r[0];
    cnt_nxt[1] = cnt_r[1];
    rdata_nxt  = '0;
    case (op_r)
      OP_TICK: begin
        for (int n = 0; n < NumTmr; n++) begin
          if (en_r[n]) begin
            if (cnt_r[n] == '0) pend_nxt[n] = 1'b1;
            cnt_nxt[n] = cnt_r[n] - count_t'(1);
          end
        end
      end
      OP_READ: begin
        unique case (addr_r)
          ADDR_IRQ:       rdata_nxt = {{(DataW-NumTmr){1'b0}}, pend_r & en_r[NumTmr-1:0]};
          ADDR_CNT_RD_LO: rdata_nxt = cnt_sel[DataW-1:0];
          ADDR_CNT_RD_HI: rdata_nxt = cnt_sel[CountW-1:DataW];
          default:        rdata_nxt = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (addr_r)
          ADDR_IRQ:      en_nxt = wdata_r;
          ADDR_TMR_STAT: pend_nxt = pend_r & ~wdata_r[NumTmr-1:0];   // write-one-to-clear
          ADDR_CNT0_LO:  cnt_nxt[0] = {cnt_r[0][CountW-1:DataW], wdata_r};
          ADDR_CNT0_HI:  cnt_nxt[0] = {wdata_r, cnt_r[0][DataW-1:0]};
          ADDR_CNT1_LO:  cnt_nxt[1] = {cnt_r[1][CountW-1:DataW], wdata_r};
          ADDR_CNT1_HI:  cnt_nxt[1] = {wdata_r, cnt_r[1][DataW-1:0]};
          default: ;
        endcase
      end
      default: ;
    endcase
    irq_nxt = |(pend_nxt & en_nxt[NumTmr-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      en_r    <= '0;
      pend_r  <= '0;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (advance) begin
        out_v_r  <= 1'b1;
        en_r     <= en_nxt;
        pend_r   <= pend_nxt;
        cnt_r[0] <= cnt_nxt[0];
        cnt_r[1] <= cnt_nxt[1];
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= op_t'(in_tuser);
      addr_r  <= in_tdata[AddrW-1:0];
      wdata_r <= in_tdata[AddrW+DataW-1:AddrW];
    end
    if (advance) begin
      rdata_r <= rdata_nxt;
      irq_r   <= irq_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, irq_r, rdata_r};

endmodule

>>> rtl/dtic_checker.sv
// Port-level checks for the dual timer interrupt controller, bound to the top level.
module dtic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a waiting input transaction is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable({in_tuser, in_tdata}))
    else $error("input changed while stalled");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input side only backs up when the result side is stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // padding bits of a result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:9] == 7'd0)
    else $error("result padding not zero");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dual_timer_irq_controller dtic_checker u_dtic_checker (.*);

>>> tb/dual_timer_irq_controller_chk.sv
// Response checker for the dual timer interrupt controller: predicts each transaction's result.
module dual_timer_irq_controller_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] address, [13:6] write_data, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [7:0] read_data, [8] irq_out, [15:9] zero
  output int          n_waiting,
  output int          n_errors
);
  import dtic_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] rd;
    logic             irq;
  } resp_t;

  logic [DataW-1:0]  irq_en;
  logic [NumTmr-1:0] irq_pend;
  count_t            timer_cnt [NumTmr];
  resp_t             resp_q [$];
  int                err_tot = 0;

  // Applies one bus transaction to the shadow state and returns the response it causes.
  function automatic resp_t bus_access(logic [1:0] op, logic [AddrW-1:0] addr,
                                       logic [DataW-1:0] wd);
    resp_t r;
    int    sel;
    r.rd = '0;
    case (op)
      OP_TICK: begin
        for (int n = 0; n < NumTmr; n++) begin
          if (irq_en[n]) begin
            if (timer_cnt[n] == '0) irq_pend[n] = 1'b1;
            timer_cnt[n] = timer_cnt[n] - count_t'(1);
          end
        end
      end
      OP_READ: begin
        // shared count read follows timer 1 only while it is pending
        sel = int'(irq_pend[1]);
        if (addr == ADDR_IRQ) r.rd = {{(DataW-NumTmr){1'b0}}, irq_pend} & irq_en;
        else if (addr == ADDR_CNT_RD_LO) r.rd = timer_cnt[sel][7:0];
        else if (addr == ADDR_CNT_RD_HI) r.rd = timer_cnt[sel][15:8];
      end
      OP_WRITE: begin
        if (addr == ADDR_IRQ) begin
          irq_en = wd;
        end else if (addr == ADDR_TMR_STAT) begin
          irq_pend = irq_pend & ~wd[NumTmr-1:0];
        end else if (addr >= ADDR_CNT0_LO && addr <= ADDR_CNT1_HI) begin
          sel = int'((addr - ADDR_CNT0_LO) >> 1);
          if (addr[0]) timer_cnt[sel][15:8] = wd;
          else timer_cnt[sel][7:0] = wd;
        end
      end
      default: ;  // reserved opcode: no state change
    endcase
    r.irq = |(irq_pend & irq_en[NumTmr-1:0]);
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t got;
    resp_t want;
    if (!rst_n) begin
      irq_en   = '0;
      irq_pend = '0;
      for (int n = 0; n < NumTmr; n++) timer_cnt[n] = '0;
      resp_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.rd  = out_tdata[7:0];
        got.irq = out_tdata[8];
        if (resp_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual read_data %02h irq %0b",
                   $time, got.rd, got.irq);
          err_tot++;
        end else begin
          want = resp_q.pop_front();
          if (got.rd !== want.rd) begin
            $display("%0t: read_data expected %02h actual %02h", $time, want.rd, got.rd);
            err_tot++;
          end
          if (got.irq !== want.irq) begin
            $display("%0t: irq_out expected %0b actual %0b", $time, want.irq, got.irq);
            err_tot++;
          end
        end
      end
      if (in_tvalid && in_tready)
        resp_q.push_back(bus_access(in_tuser, in_tdata[5:0], in_tdata[13:6]));
    end
    n_waiting <= resp_q.size();
    n_errors  <= err_tot;
  end

endmodule

>>> tb/dual_timer_irq_controller_tb.sv
// Testbench top for the dual timer interrupt controller: stimulus, flow control and verdict.
module dual_timer_irq_controller_tb;
  import dtic_pkg::*;

  localparam logic [1:0] OP_RSVD = 2'd3;
  localparam int         LIMIT   = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [5:0] address, [13:6] write_data, [15:14] zero
  logic [1:0]  in_tuser;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] read_data, [8] irq_out, [15:9] zero

  int n_waiting;
  int n_errors;
  int cycles  = 0;
  int rx_seen = 0;
  bit held    = 1'b0;
  bit gaps_on = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dual_timer_irq_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dual_timer_irq_controller_chk resp_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .n_waiting  (n_waiting),
    .n_errors   (n_errors)
  );

  // Offers one transaction and returns at the edge where it is taken.
  task automatic push_item(input logic [1:0] op, input logic [AddrW-1:0] addr,
                           input logic [DataW-1:0] wd);
    while (gaps_on && $urandom_range(0, 99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, wd, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Biased toward ticks, count/status reads and small timer loads so timers expire often.
  task automatic push_random();
    logic [1:0]       op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wd;
    int               pick;
    pick = $urandom_range(0, 99);
    addr = AddrW'($urandom_range(0, 63));
    wd   = DataW'($urandom_range(0, 255));
    if (pick < 45) begin
      op = OP_TICK;
    end else if (pick < 70) begin
      op = OP_READ;
      case ($urandom_range(0, 4))
        0: addr = ADDR_IRQ;
        1: addr = ADDR_CNT_RD_LO;
        2: addr = ADDR_CNT_RD_HI;
        default: ;
      endcase
    end else if (pick < 95) begin
      op = OP_WRITE;
      case ($urandom_range(0, 5))
        0: begin
          addr = ADDR_IRQ;
          if ($urandom_range(0, 3) != 0) wd[1:0] = 2'b11;
        end
        1: addr = ADDR_TMR_STAT;
        2: begin
          addr = $urandom_range(0, 1) ? ADDR_CNT0_LO : ADDR_CNT1_LO;
          if ($urandom_range(0, 3) != 0) wd = DataW'($urandom_range(0, 6));
        end
        3: begin
          addr = $urandom_range(0, 1) ? ADDR_CNT0_HI : ADDR_CNT1_HI;
          if ($urandom_range(0, 3) != 0) wd = '0;
        end
        default: ;
      endcase
    end else begin
      op = OP_RSVD;
    end
    push_item(op, addr, wd);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_TICK;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    push_item(OP_READ,  ADDR_IRQ,       8'h00);
    push_item(OP_READ,  ADDR_CNT_RD_LO, 8'h00);
    push_item(OP_TICK,  6'd0,           8'h00);  // both timers disabled
    push_item(OP_WRITE, ADDR_IRQ,       8'hff);  // upper enable bits stored too
    push_item(OP_READ,  ADDR_IRQ,       8'h00);
    push_item(OP_WRITE, ADDR_CNT1_LO,   8'h01);
    push_item(OP_WRITE, ADDR_CNT1_HI,   8'h00);
    push_item(OP_TICK,  6'd0,           8'h00);  // timer 0 expires from zero and wraps
    push_item(OP_READ,  ADDR_CNT_RD_LO, 8'h00);
    push_item(OP_READ,  ADDR_CNT_RD_HI, 8'h00);
    push_item(OP_TICK,  6'd63,          8'hff);  // timer 1 expires
    push_item(OP_READ,  ADDR_CNT_RD_LO, 8'h00);  // now selects timer 1
    push_item(OP_READ,  ADDR_IRQ,       8'h00);
    push_item(OP_WRITE, ADDR_TMR_STAT,  8'h01);
    push_item(OP_WRITE, ADDR_TMR_STAT,  8'hfe);
    push_item(OP_WRITE, ADDR_CNT_RD_LO, 8'haa);  // read-only, ignored
    push_item(OP_READ,  ADDR_TMR_STAT,  8'h00);
    push_item(OP_READ,  ADDR_CNT0_HI,   8'h00);
    push_item(OP_READ,  6'd63,          8'h00);
    push_item(OP_WRITE, 6'd63,          8'h55);
    push_item(OP_RSVD,  6'd63,          8'hff);
    push_item(OP_WRITE, ADDR_CNT0_HI,   8'hff);
    push_item(OP_WRITE, ADDR_CNT0_LO,   8'h00);
    push_item(OP_WRITE, ADDR_IRQ,       8'h00);
    push_item(OP_TICK,  6'd0,           8'h00);
    push_item(OP_READ,  ADDR_CNT_RD_HI, 8'h00);

    for (int i = 0; i < 800; i++) begin
      gaps_on = !(i >= 400 && i < 550);
      push_random();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0 && n_waiting == 0) $display("dual_timer_irq_controller_tb: clean");
    else $display("dual_timer_irq_controller_tb: errors");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off to back up the pipeline.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) rx_seen++;
      if (!held && rx_seen >= 300) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (250) @(posedge clk);
      end else begin
        out_tready <= !(gaps_on && $urandom_range(0, 99) < 18);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("dual_timer_irq_controller_tb: errors");
      $finish;
    end
  end

endmodule

>>> dual_timer_irq_controller.f
rtl/dtic_pkg.sv
rtl/dual_timer_irq_controller.sv
rtl/dtic_checker.sv
tb/dual_timer_irq_controller_chk.sv
tb/dual_timer_irq_controller_tb.sv
